// ----- sv/dipid_pkg.sv -----
package dipid_pkg;

	localparam int DataW = 16;
	localparam int ErrW  = DataW + 1;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KP_LEFT  = 3'd0,
		REG_KI_LEFT  = 3'd1,
		REG_KD_LEFT  = 3'd2,
		REG_KP_RIGHT = 3'd3,
		REG_KI_RIGHT = 3'd4,
		REG_KD_RIGHT = 3'd5,
		REG_OUT_MIN  = 3'd6,
		REG_OUT_MAX  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [DataW-1:0] kp;
		logic [DataW-1:0] ki;
		logic [DataW-1:0] kd;
	} gains_t;

	typedef struct packed {
		gains_t                   left;
		gains_t                   right;
		logic signed [DataW-1:0]  out_min;
		logic signed [DataW-1:0]  out_max;
	} cfg_t;

	localparam logic [DataW-1:0] KpLeftRst  = 16'd768;
	localparam logic [DataW-1:0] KiLeftRst  = 16'd82;
	localparam logic [DataW-1:0] KdLeftRst  = 16'd38;
	localparam logic [DataW-1:0] KpRightRst = 16'd768;
	localparam logic [DataW-1:0] KiRightRst = 16'd72;
	localparam logic [DataW-1:0] KdRightRst = 16'd26;
	localparam logic signed [DataW-1:0] OutMinRst = -16'sd10000;
	localparam logic signed [DataW-1:0] OutMaxRst = 16'sd10000;

endpackage

// ----- sv/dipid_cfg.sv -----
module dipid_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dipid_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [dipid_pkg::DataW-1:0]       cfg_wdata,
	output dipid_pkg::cfg_t                   cfg
);

	dipid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left.kp  <= dipid_pkg::KpLeftRst;
			cfg_q.left.ki  <= dipid_pkg::KiLeftRst;
			cfg_q.left.kd  <= dipid_pkg::KdLeftRst;
			cfg_q.right.kp <= dipid_pkg::KpRightRst;
			cfg_q.right.ki <= dipid_pkg::KiRightRst;
			cfg_q.right.kd <= dipid_pkg::KdRightRst;
			cfg_q.out_min  <= dipid_pkg::OutMinRst;
			cfg_q.out_max  <= dipid_pkg::OutMaxRst;
		end else if (cfg_we) begin
			case (dipid_pkg::cfg_reg_t'(cfg_index))
				dipid_pkg::REG_KP_LEFT:  cfg_q.left.kp  <= cfg_wdata;
				dipid_pkg::REG_KI_LEFT:  cfg_q.left.ki  <= cfg_wdata;
				dipid_pkg::REG_KD_LEFT:  cfg_q.left.kd  <= cfg_wdata;
				dipid_pkg::REG_KP_RIGHT: cfg_q.right.kp <= cfg_wdata;
				dipid_pkg::REG_KI_RIGHT: cfg_q.right.ki <= cfg_wdata;
				dipid_pkg::REG_KD_RIGHT: cfg_q.right.kd <= cfg_wdata;
				dipid_pkg::REG_OUT_MIN:  cfg_q.out_min  <= signed'(cfg_wdata);
				dipid_pkg::REG_OUT_MAX:  cfg_q.out_max  <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/dipid_wheel.sv -----
module dipid_wheel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                clr,
	input  logic signed [dipid_pkg::DataW-1:0]  target,
	input  logic signed [dipid_pkg::DataW-1:0]  measured,
	input  dipid_pkg::gains_t                   gains,
	input  logic signed [dipid_pkg::DataW-1:0]  out_min,
	input  logic signed [dipid_pkg::DataW-1:0]  out_max,
	output logic signed [dipid_pkg::DataW-1:0]  drive
);

	localparam int EW   = dipid_pkg::ErrW;
	localparam int DW   = dipid_pkg::DataW;
	localparam int AccW = EW + DW + 5;
	localparam int DelW = AccW - 8;
	localparam int SumW = DelW + 1;

	logic signed [EW-1:0]   err_last_q, err_prev_q;
	logic signed [DW-1:0]   out_last_q;

	logic signed [EW-1:0]   err;
	logic signed [EW:0]     d1;
	logic signed [EW+1:0]   d2;
	logic signed [AccW-1:0] p_term, i_term, d_term, acc, acc_rnd;
	logic signed [DelW-1:0] delta;
	logic signed [SumW-1:0] sum, lo, hi;

	always_comb begin
		err = EW'(target) - EW'(measured);
		d1  = (EW+1)'(err) - (EW+1)'(err_last_q);
		d2  = (EW+2)'(err) - ((EW+2)'(err_last_q) <<< 1) + (EW+2)'(err_prev_q);
		// gains are unsigned: widen with a zero sign bit before the signed multiply
		p_term = AccW'(signed'({1'b0, gains.kp}) * d1);
		i_term = AccW'(signed'({1'b0, gains.ki}) * err);
		d_term = AccW'(signed'({1'b0, gains.kd}) * d2);
		acc    = p_term + i_term + d_term;
		// Q8.8 to integer, truncating toward zero
		acc_rnd = acc + (acc[AccW-1] ? AccW'(255) : AccW'(0));
		delta   = DelW'(acc_rnd >>> 8);
		sum = SumW'(out_last_q) + SumW'(delta);
		lo  = SumW'(out_min);
		hi  = SumW'(out_max);
		if (sum < lo)
			drive = out_min;
		else if (sum > hi)
			drive = out_max;
		else
			drive = DW'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_last_q <= '0;
			err_prev_q <= '0;
			out_last_q <= '0;
		end else if (load) begin
			if (clr) begin
				err_last_q <= '0;
				err_prev_q <= '0;
				out_last_q <= '0;
			end else begin
				err_prev_q <= err_last_q;
				err_last_q <= err;
				out_last_q <= drive;
			end
		end
	end

endmodule

// ----- sv/dual_incremental_pid_speed.sv -----
// Two independent incremental PID speed loops, left and right wheel. Each input
// transaction carries both targets and both measured speeds; each output transaction
// carries both clamped drive values. An input lands in an input register, the PID
// update for both wheels runs in combinational logic (three multipliers per wheel),
// and the result goes to an output register; one transaction is accepted per cycle
// as long as the output side keeps up. Error and output history update as a result
// enters the output register. Both targets zero clears all history and yields zero
// drives. Gains and clamps are to be written through the cfg port only while the
// block is idle; the block itself does not enforce this.
module dual_incremental_pid_speed (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dipid_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [dipid_pkg::DataW-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// target_left, target_right, measured_left, measured_right
	input  logic [4*dipid_pkg::DataW-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// drive_left, drive_right
	output logic [2*dipid_pkg::DataW-1:0]     m_tdata
);

	localparam int DW = dipid_pkg::DataW;

	dipid_pkg::cfg_t cfg;

	logic                 valid_s1, valid_s2;
	logic [4*DW-1:0]      data_s1;
	logic [2*DW-1:0]      data_s2;
	logic                 adv2;
	logic                 zero_s1;
	logic signed [DW-1:0] drive_l, drive_r;

	dipid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv2     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv2;
	assign zero_s1  = (data_s1[DW-1:0] == '0) && (data_s1[2*DW-1:DW] == '0);

	dipid_wheel u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv2),
		.clr      (zero_s1),
		.target   (signed'(data_s1[DW-1:0])),
		.measured (signed'(data_s1[3*DW-1:2*DW])),
		.gains    (cfg.left),
		.out_min  (cfg.out_min),
		.out_max  (cfg.out_max),
		.drive    (drive_l)
	);

	dipid_wheel u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv2),
		.clr      (zero_s1),
		.target   (signed'(data_s1[2*DW-1:DW])),
		.measured (signed'(data_s1[4*DW-1:3*DW])),
		.gains    (cfg.right),
		.out_min  (cfg.out_min),
		.out_max  (cfg.out_max),
		.drive    (drive_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
		if (adv2)
			data_s2 <= zero_s1 ? '0 : {drive_r, drive_l};
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && zero_s1) |=> (m_tdata == '0))
		else $error("zero targets did not give zero drives");

	a_input_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> m_tvalid)
		else $error("advanced transaction missing from output register");

	a_stage1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv2 && !(s_tvalid && s_tready)) |=> valid_s1)
		else $error("held input transaction lost");

endmodule

// ----- tb/dual_incremental_pid_speed_chk.sv -----
module dual_incremental_pid_speed_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dipid_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [dipid_pkg::DataW-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// target_left, target_right, measured_left, measured_right
	input  logic [4*dipid_pkg::DataW-1:0]     s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// drive_left, drive_right
	input  logic [2*dipid_pkg::DataW-1:0]     m_tdata,
	output int                                fail_count,
	output int                                checked,
	output int                                pending
);
	import dipid_pkg::*;

	localparam int ReportCap = 100;

	typedef struct packed {
		logic signed [ErrW-1:0]  err_last;
		logic signed [ErrW-1:0]  err_prev;
		logic signed [DataW-1:0] drive;
	} wheel_hist_t;

	typedef struct packed {
		logic signed [DataW-1:0] left;
		logic signed [DataW-1:0] right;
	} drive_pair_t;

	cfg_t        shadow_cfg;
	wheel_hist_t left_hist, right_hist;
	drive_pair_t expected_drives[$];
	drive_pair_t observed, awaited, predicted;
	logic signed [DataW-1:0] tgt_l, tgt_r, meas_l, meas_r;

	// One incremental update of a single wheel; returns the new history.
	function automatic wheel_hist_t pid_update(input wheel_hist_t h,
			input logic signed [DataW-1:0] tgt, input logic signed [DataW-1:0] meas,
			input gains_t g, input logic signed [DataW-1:0] lo,
			input logic signed [DataW-1:0] hi);
		longint err, acc, step, sum;
		wheel_hist_t nxt;
		err = longint'(tgt) - longint'(meas);
		acc = longint'(g.kp) * (err - longint'($signed(h.err_last)))
			+ longint'(g.ki) * err
			+ longint'(g.kd) * (err - 2 * longint'($signed(h.err_last))
				+ longint'($signed(h.err_prev)));
		// Q8.8 -> integer, toward zero
		step = (acc < 0) ? -((-acc) >>> 8) : (acc >>> 8);
		sum = longint'($signed(h.drive)) + step;
		if (sum < longint'(lo))
			sum = longint'(lo);
		else if (sum > longint'(hi))
			sum = longint'(hi);
		nxt.err_prev = h.err_last;
		nxt.err_last = err[ErrW-1:0];
		nxt.drive = sum[DataW-1:0];
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg.left.kp = KpLeftRst;
			shadow_cfg.left.ki = KiLeftRst;
			shadow_cfg.left.kd = KdLeftRst;
			shadow_cfg.right.kp = KpRightRst;
			shadow_cfg.right.ki = KiRightRst;
			shadow_cfg.right.kd = KdRightRst;
			shadow_cfg.out_min = OutMinRst;
			shadow_cfg.out_max = OutMaxRst;
			left_hist = '0;
			right_hist = '0;
			expected_drives.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_KP_LEFT:  shadow_cfg.left.kp = cfg_wdata;
					REG_KI_LEFT:  shadow_cfg.left.ki = cfg_wdata;
					REG_KD_LEFT:  shadow_cfg.left.kd = cfg_wdata;
					REG_KP_RIGHT: shadow_cfg.right.kp = cfg_wdata;
					REG_KI_RIGHT: shadow_cfg.right.ki = cfg_wdata;
					REG_KD_RIGHT: shadow_cfg.right.kd = cfg_wdata;
					REG_OUT_MIN:  shadow_cfg.out_min = cfg_wdata;
					REG_OUT_MAX:  shadow_cfg.out_max = cfg_wdata;
					default: ;
				endcase
			end

			// compare before predicting: a result can never belong to an input
			// accepted at the same edge
			if (m_tvalid && m_tready) begin
				observed.left = m_tdata[DataW-1:0];
				observed.right = m_tdata[2*DataW-1:DataW];
				if (expected_drives.size() == 0) begin
					if (fail_count < ReportCap)
						$display("%0t: unexpected drive transaction, left %0d right %0d",
							$time, observed.left, observed.right);
					fail_count++;
				end else begin
					awaited = expected_drives.pop_front();
					checked++;
					if (observed.left !== awaited.left) begin
						if (fail_count < ReportCap)
							$display("%0t: drive_left expected %0d, got %0d",
								$time, awaited.left, observed.left);
						fail_count++;
					end
					if (observed.right !== awaited.right) begin
						if (fail_count < ReportCap)
							$display("%0t: drive_right expected %0d, got %0d",
								$time, awaited.right, observed.right);
						fail_count++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				tgt_l = s_tdata[DataW-1:0];
				tgt_r = s_tdata[2*DataW-1:DataW];
				meas_l = s_tdata[3*DataW-1:2*DataW];
				meas_r = s_tdata[4*DataW-1:3*DataW];
				if (tgt_l == 0 && tgt_r == 0) begin
					// stop request: both loops forget everything
					left_hist = '0;
					right_hist = '0;
				end else begin
					left_hist = pid_update(left_hist, tgt_l, meas_l, shadow_cfg.left,
						shadow_cfg.out_min, shadow_cfg.out_max);
					right_hist = pid_update(right_hist, tgt_r, meas_r, shadow_cfg.right,
						shadow_cfg.out_min, shadow_cfg.out_max);
				end
				predicted.left = left_hist.drive;
				predicted.right = right_hist.drive;
				expected_drives.push_back(predicted);
			end
		end
		pending = expected_drives.size();
	end

endmodule

// ----- tb/dual_incremental_pid_speed_tb.sv -----
module dual_incremental_pid_speed_tb;
	import dipid_pkg::*;

	localparam int IdleLimit  = 1000;
	localparam int PhaseItems = 117;
	localparam int PhaseCount = 8;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]     cfg_index = REG_KP_LEFT;
	logic [DataW-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// target_left, target_right, measured_left, measured_right
	logic [4*DataW-1:0]     s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// drive_left, drive_right
	logic [2*DataW-1:0]     m_tdata;

	int       fail_count, checked, pending;
	int       idle_cycles = 0;
	int       items_sent = 0;
	int       settings_used = 1;
	int       burst_left = 0;
	int       set_l = 0, set_r = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_hold = 0;
	int       rx_tick = 0;

	dual_incremental_pid_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	dual_incremental_pid_speed_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.checked    (checked),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver backpressure: switch between stall styles every so often
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(16, 128);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_mode)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_tready <= (rx_tick % 5 != 0);
			default:     m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("dual_incremental_pid_speed_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [DataW-1:0] sat16(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[DataW-1:0];
	endfunction

	function automatic logic [DataW-1:0] pick_gain();
		return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
	endfunction

	// mostly moderate wheel speeds, now and then anywhere in range
	function automatic int speed_setpoint();
		if ($urandom_range(0, 7) == 0)
			return int'($signed(16'($urandom)));
		return int'($urandom_range(0, 6000)) - 3000;
	endfunction

	task automatic send_speeds(input logic signed [DataW-1:0] tl,
			input logic signed [DataW-1:0] tr, input logic signed [DataW-1:0] ml,
			input logic signed [DataW-1:0] mr);
		s_tvalid <= 1'b1;
		s_tdata <= {mr, ml, tr, tl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// hold off until every drive result is back; pending is settled by negedge
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [DataW-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [DataW-1:0] kpl, input logic [DataW-1:0] kil,
			input logic [DataW-1:0] kdl, input logic [DataW-1:0] kpr,
			input logic [DataW-1:0] kir, input logic [DataW-1:0] kdr,
			input logic [DataW-1:0] lo, input logic [DataW-1:0] hi);
		cfg_write(REG_KP_LEFT, kpl);
		cfg_write(REG_KI_LEFT, kil);
		cfg_write(REG_KD_LEFT, kdl);
		cfg_write(REG_KP_RIGHT, kpr);
		cfg_write(REG_KI_RIGHT, kir);
		cfg_write(REG_KD_RIGHT, kdr);
		cfg_write(REG_OUT_MIN, lo);
		cfg_write(REG_OUT_MAX, hi);
		settings_used++;
	endtask

	task automatic random_item();
		int pick;
		logic signed [DataW-1:0] tl, tr, ml, mr;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			// stop request with junk measurements
			tl = '0;
			tr = '0;
			ml = 16'($urandom);
			mr = 16'($urandom);
		end else if (pick < 20) begin
			tl = 16'($urandom);
			tr = 16'($urandom);
			ml = 16'($urandom);
			mr = 16'($urandom);
		end else begin
			if (pick < 26) begin
				set_l = speed_setpoint();
				set_r = speed_setpoint();
			end
			// closed-loop looking traffic: measured speed hovers near target
			tl = sat16(set_l + int'($urandom_range(0, 16)) - 8);
			tr = sat16(set_r + int'($urandom_range(0, 16)) - 8);
			ml = sat16(set_l + int'($urandom_range(0, 1400)) - 700);
			mr = sat16(set_r + int'($urandom_range(0, 1400)) - 700);
		end
		send_speeds(tl, tr, ml, mr);
	endtask

	task automatic run_items(input int count);
		int gap;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				pause(gap);
			end
			random_item();
			burst_left--;
		end
	endtask

	initial begin
		int lo_b, hi_b, swap;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, power-on gains and clamps
		send_speeds(100, -100, 0, 0);
		send_speeds(100, -100, 50, -80);
		send_speeds(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_speeds(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_speeds(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
		send_speeds(0, 0, 1234, -1234);
		send_speeds(0, 500, 0, 0);
		send_speeds(700, 0, 0, 100);
		send_speeds(0, 0, 16'sh8000, 16'sh7FFF);
		send_speeds(-1, -1, 0, 0);
		send_speeds(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
		send_speeds(16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA);
		send_speeds(1, 1, 1, 1);
		send_speeds(-3000, 3000, -2900, 3100);
		drain();

		for (int phase = 0; phase < PhaseCount; phase++) begin
			case (phase)
				0: ;
				1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'h8000, 16'h7FFF);
				2: set_config('0, '0, '0, '0, '0, '0, 16'(-300), 16'(300));
				// inverted bounds
				3: set_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
					pick_gain(), pick_gain(), 16'(500), 16'(-500));
				4: set_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
					pick_gain(), pick_gain(), 16'(1234), 16'(1234));
				default: begin
					lo_b = int'($urandom_range(0, 65535)) - 32768;
					hi_b = int'($urandom_range(0, 65535)) - 32768;
					if (lo_b > hi_b) begin
						swap = lo_b;
						lo_b = hi_b;
						hi_b = swap;
					end
					set_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
						pick_gain(), pick_gain(), 16'(lo_b), 16'(hi_b));
				end
			endcase
			run_items(PhaseItems);
			drain();
		end

		repeat (8) @(posedge clk);
		$display("%0d speed transactions over %0d gain/clamp settings, %0d drive results checked",
			items_sent, settings_used, checked);
		if (fail_count == 0)
			$display("dual_incremental_pid_speed_tb passed");
		else
			$display("dual_incremental_pid_speed_tb failed");
		$finish;
	end

endmodule

// ----- dual_incremental_pid_speed.f -----
sv/dipid_pkg.sv
sv/dipid_cfg.sv
sv/dipid_wheel.sv
sv/dual_incremental_pid_speed.sv
tb/dual_incremental_pid_speed_chk.sv
tb/dual_incremental_pid_speed_tb.sv
